// ===== design/salloc_pkg.sv =====
`default_nettype none

package salloc_pkg;

    // chunk geometry
    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // slot_limit register
    localparam int LIMIT_W = 11;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

    // request depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic             is_free;
        logic [IDX_W-1:0] slot;
    } req_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/salloc_front.sv =====
`default_nettype none

module salloc_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic                     opcode,
    input  wire logic [salloc_pkg::IDX_W-1:0] slot_index,
    output logic                          req_valid,
    output salloc_pkg::req_t              req,
    input  wire logic                     req_take
);
    import salloc_pkg::*;

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;
    req_t              classified;

    // classify the incoming transfer
    always_comb
    begin
        classified.is_free = (opcode == OP_FREE);
        classified.slot    = slot_index;
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_wr     = push && !full;
    assign req_valid = (count_reg != '0);
    assign do_rd     = req_take && req_valid;
    assign req       = entry_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/salloc_back.sv =====
`default_nettype none

module salloc_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [salloc_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                           req_valid,
    input  wire salloc_pkg::req_t               req,
    output logic                                req_take,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [1:0]                          status,
    output logic [salloc_pkg::IDX_W-1:0]        granted_slot,
    output logic                                is_empty,
    output logic                                is_full
);
    import salloc_pkg::*;

    logic [IDX_W-1:0]   stack_mem [SLOTS];
    logic [IDX_W-1:0]   rd_data_reg;

    back_state_t        state_reg, state_next;
    req_t               req_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   boundary_reg, boundary_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [IDX_W-1:0]   granted_reg, granted_next;
    logic               empty_flag_reg, empty_flag_next;
    logic               full_flag_reg, full_flag_next;

    logic               rd_en;
    logic               wr_en;
    logic [CNT_W-1:0]   eff_limit;
    logic [CNT_W-1:0]   slot_ext;
    logic [CNT_W-1:0]   top_addr;

    assign eff_limit = (CNT_W'(limit_reg) < CNT_W'(SLOTS)) ? CNT_W'(limit_reg) : CNT_W'(SLOTS);
    assign slot_ext  = CNT_W'(req_reg.slot);
    assign top_addr  = count_reg - 1'b1;

    // sequencer: fetch top of stack, then execute
    always_comb
    begin
        state_next      = state_reg;
        boundary_next   = boundary_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !pop;
        status_next     = status_reg;
        granted_next    = granted_reg;
        empty_flag_next = empty_flag_reg;
        full_flag_next  = full_flag_reg;
        req_take        = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_take   = 1'b1;
                    rd_en      = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || pop)
                begin
                    status_next  = ST_OK;
                    granted_next = '0;
                    if (!req_reg.is_free)
                    begin
                        // allocate: stack first, then bump
                        if (count_reg != '0)
                        begin
                            count_next   = count_reg - 1'b1;
                            granted_next = rd_data_reg;
                        end
                        else if (boundary_reg < eff_limit)
                        begin
                            granted_next  = boundary_reg[IDX_W-1:0];
                            boundary_next = boundary_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    else if (slot_ext >= boundary_reg)
                    begin
                        status_next = ST_BAD;
                    end
                    else
                    begin
                        // free: lower the boundary or stack the slot
                        if (slot_ext + 1'b1 == boundary_reg)
                        begin
                            boundary_next = slot_ext;
                        end
                        else if (count_reg < CNT_W'(SLOTS))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        // chunk drained
                        if (count_next == boundary_next)
                        begin
                            boundary_next = '0;
                            count_next    = '0;
                        end
                    end
                    empty_flag_next = (count_next == boundary_next);
                    full_flag_next  = (boundary_next >= eff_limit) && (count_next == '0);
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[top_addr[IDX_W-1:0]];
        end
        if (wr_en)
        begin
            stack_mem[count_reg[IDX_W-1:0]] <= req_reg.slot;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        status_reg     <= status_next;
        granted_reg    <= granted_next;
        empty_flag_reg <= empty_flag_next;
        full_flag_reg  <= full_flag_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            boundary_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            boundary_reg  <= boundary_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign is_empty     = empty_flag_reg;
    assign is_full      = full_flag_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("free count past stack depth");

    a_boundary_bound: assert property (@(posedge clk) disable iff (!rst_n)
        boundary_reg <= CNT_W'(SLOTS))
        else $error("boundary past slot count");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(status_reg)
            && $stable(granted_reg))
        else $error("waiting result lost or changed");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC && !out_valid_reg |=> state_reg == S_IDLE && out_valid_reg)
        else $error("request not executed");

    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> $stable(boundary_reg) && $stable(count_reg))
        else $error("state changed without a request");

endmodule

`default_nettype wire

// ===== design/bump_and_lifo_free_slot_allocator_unit.sv =====
`default_nettype none
// flow: the back end takes a request from the queue together with the registered free
//   stack read that precedes each execute step, then executes it and registers the result;
//   it takes no new request until then, and a 2-entry request queue takes pushes meanwhile
// reset: rst_n asynchronous, active low; boundary and free count clear, slot_limit
//   returns to 1024, stack memory contents are left as they are (no clearing pass)

module bump_and_lifo_free_slot_allocator_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [salloc_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic                           opcode,
    input  wire logic [salloc_pkg::IDX_W-1:0]   slot_index,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [1:0]                          status,
    output logic [salloc_pkg::IDX_W-1:0]        granted_slot,
    output logic                                is_empty,
    output logic                                is_full
);
    import salloc_pkg::*;

    logic req_valid;
    req_t req;
    logic req_take;

    // accept and classify
    salloc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .slot_index (slot_index),
        .req_valid  (req_valid),
        .req        (req),
        .req_take   (req_take)
    );

    // allocate and free
    salloc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req          (req),
        .req_take     (req_take),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .granted_slot (granted_slot),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import salloc_pkg::*;

    // kinds of row in the directed table
    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted;
        logic             empty_flag;
        logic             full_flag;
    } alloc_result_t;

    typedef struct {
        row_kind_t          kind;
        logic               op;
        logic [IDX_W-1:0]   slot;
        logic [LIMIT_W-1:0] limit;
        bit                 typed;
        alloc_result_t      res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [LIMIT_W-1:0]  cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic                opcode = OP_ALLOC;
    logic [IDX_W-1:0]    slot_index = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [1:0]          status;
    logic [IDX_W-1:0]    granted_slot;
    logic                is_empty;
    logic                is_full;

    // shadow of the allocator state
    logic [LIMIT_W-1:0]  limit_reg = LIMIT_RESET;
    logic [CNT_W-1:0]    bump = '0;
    logic [CNT_W-1:0]    stacked = '0;
    logic [IDX_W-1:0]    free_slots [0:SLOTS-1];

    alloc_result_t       pending_results [$];
    logic [IDX_W-1:0]    lent_slots [$];
    dir_row_t            dir_rows [$];
    int                  errors = 0;
    int                  burst_left = 0;

    // random phases: limit, item count, share of allocates in percent
    int phase_limit [10] = '{16, 1024, 40, 2047, 0, 1, 2, 1024, 5, 1023};
    int phase_items [10] = '{100, 1150, 80, 80, 30, 40, 40, 100, 60, 60};
    int phase_alloc [10] = '{55, 95, 50, 60, 40, 50, 50, 50, 55, 70};

    bump_and_lifo_free_slot_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .granted_slot (granted_slot),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    always #6 clk = ~clk;

    // one request against the shadow state
    function automatic alloc_result_t alloc_step(input logic op, input logic [IDX_W-1:0] slot);
        alloc_result_t r;
        int            lim;
        r.status = ST_OK;
        r.granted = '0;
        lim = (int'(limit_reg) < SLOTS) ? int'(limit_reg) : SLOTS;
        if (op == OP_ALLOC)
        begin
            if (stacked != 0)
            begin
                stacked = stacked - 1'b1;
                r.granted = free_slots[stacked];
            end
            else if (int'(bump) < lim)
            begin
                r.granted = bump[IDX_W-1:0];
                bump = bump + 1'b1;
            end
            else
                r.status = ST_FULL;
        end
        else
        begin
            if (int'(slot) >= int'(bump))
                r.status = ST_BAD;
            else
            begin
                // freeing the top slot lowers the boundary, anything else is stacked
                if (int'(slot) + 1 == int'(bump))
                    bump = CNT_W'(slot);
                else if (int'(stacked) < SLOTS)
                begin
                    free_slots[stacked] = slot;
                    stacked = stacked + 1'b1;
                end
                if (stacked == bump)
                begin
                    bump = '0;
                    stacked = '0;
                end
            end
        end
        r.empty_flag = (stacked == bump);
        r.full_flag = (int'(bump) >= lim) && (stacked == 0);
        return r;
    endfunction

    function automatic dir_row_t item_row(input logic op, input logic [IDX_W-1:0] slot);
        dir_row_t d;
        d.kind = ROW_ITEM;
        d.op = op;
        d.slot = slot;
        d.limit = '0;
        d.typed = 1'b0;
        d.res = '{ST_OK, '0, 1'b0, 1'b0};
        return d;
    endfunction

    function automatic dir_row_t checked_row(input logic op, input logic [IDX_W-1:0] slot,
                                             input logic [1:0] st, input logic [IDX_W-1:0] gs,
                                             input logic em, input logic fu);
        dir_row_t d;
        d = item_row(op, slot);
        d.typed = 1'b1;
        d.res = '{st, gs, em, fu};
        return d;
    endfunction

    function automatic dir_row_t cfg_row(input logic [LIMIT_W-1:0] v);
        dir_row_t d;
        d = item_row(OP_ALLOC, '0);
        d.kind = ROW_CFG;
        d.limit = v;
        return d;
    endfunction

    // wait until every expected result has been transferred
    task automatic drain();
        push = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        limit_reg = v;
    endtask

    // offer one request in bursts with random gaps, predict on transfer
    task automatic send_item(input logic op, input logic [IDX_W-1:0] slot,
                             input bit typed, input alloc_result_t typed_res);
        alloc_result_t pred;
        int            gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                push = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push = 1'b1;
        opcode = op;
        slot_index = slot;
        do
            @(posedge clk);
        while (full);
        pred = alloc_step(op, slot);
        pending_results.push_back(typed ? typed_res : pred);
        if (op == OP_ALLOC && pred.status == ST_OK)
            lent_slots.push_back(pred.granted);
        if (pred.empty_flag)
            lent_slots.delete();
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d slot %0d", $time, status,
                         granted_slot);
                errors++;
            end
            else
            begin
                e = pending_results[0];
                pending_results.delete(0);
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, e.status, status);
                    errors++;
                end
                if (granted_slot !== e.granted)
                begin
                    $display("%0t: granted_slot expected %0d got %0d", $time, e.granted,
                             granted_slot);
                    errors++;
                end
                if (is_empty !== e.empty_flag)
                begin
                    $display("%0t: is_empty expected %0d got %0d", $time, e.empty_flag,
                             is_empty);
                    errors++;
                end
                if (is_full !== e.full_flag)
                begin
                    $display("%0t: is_full expected %0d got %0d", $time, e.full_flag, is_full);
                    errors++;
                end
            end
        end
    end

    // receiver stalls: free running, coin toss, or long holds
    initial
    begin : receiver
        int mode;
        int mode_left;
        int stall_left;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                0: pop = 1'b1;
                1: pop = $urandom_range(0, 1);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        pop = 1'b0;
                        stall_left--;
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        pop = 1'b0;
                        stall_left = $urandom_range(1, 12);
                    end
                    else
                        pop = 1'b1;
                end
            endcase
        end
    end

    initial
    begin : stimulus
        alloc_result_t none;
        dir_row_t      d;
        logic          op;
        logic [IDX_W-1:0] slot;
        int            pick;

        none = '{ST_OK, '0, 1'b0, 1'b0};

        // directed table
        dir_rows.push_back(checked_row(OP_ALLOC, 10'd0, ST_OK, 10'd0, 1'b0, 1'b0));
        dir_rows.push_back(checked_row(OP_FREE, 10'd1023, ST_BAD, 10'd0, 1'b0, 1'b0));
        dir_rows.push_back(item_row(OP_ALLOC, 10'd1023));
        dir_rows.push_back(item_row(OP_ALLOC, 10'd0));
        dir_rows.push_back(item_row(OP_FREE, 10'd0));
        dir_rows.push_back(item_row(OP_FREE, 10'd1));
        // stacked count meets lowered boundary: chunk empties
        dir_rows.push_back(item_row(OP_FREE, 10'd2));
        dir_rows.push_back(checked_row(OP_ALLOC, 10'd0, ST_OK, 10'd0, 1'b0, 1'b0));
        dir_rows.push_back(item_row(OP_ALLOC, 10'd0));
        dir_rows.push_back(item_row(OP_ALLOC, 10'd0));
        dir_rows.push_back(item_row(OP_FREE, 10'd1));
        // most recently freed slot comes back first
        dir_rows.push_back(item_row(OP_ALLOC, 10'd0));
        dir_rows.push_back(item_row(OP_FREE, 10'd2));
        dir_rows.push_back(item_row(OP_FREE, 10'd1));
        dir_rows.push_back(item_row(OP_FREE, 10'd0));
        // zero limit refuses every bump
        dir_rows.push_back(cfg_row(11'd0));
        dir_rows.push_back(checked_row(OP_ALLOC, 10'd0, ST_FULL, 10'd0, 1'b1, 1'b1));
        dir_rows.push_back(checked_row(OP_FREE, 10'd0, ST_BAD, 10'd0, 1'b1, 1'b1));
        dir_rows.push_back(cfg_row(11'd1));
        dir_rows.push_back(checked_row(OP_ALLOC, 10'd1023, ST_OK, 10'd0, 1'b0, 1'b1));
        dir_rows.push_back(checked_row(OP_ALLOC, 10'd0, ST_FULL, 10'd0, 1'b0, 1'b1));
        dir_rows.push_back(item_row(OP_FREE, 10'd0));
        // limit past the slot count is clipped
        dir_rows.push_back(cfg_row(11'd2047));
        dir_rows.push_back(item_row(OP_ALLOC, 10'd0));
        dir_rows.push_back(item_row(OP_FREE, 10'd0));
        dir_rows.push_back(cfg_row(11'd1024));

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            d = dir_rows[i];
            if (d.kind == ROW_CFG)
                write_limit(d.limit);
            else
                send_item(d.op, d.slot, d.typed, d.res);
        end

        // random phases, state carried over so limits also drop below the boundary
        for (int p = 0; p < 10; p++)
        begin
            write_limit(LIMIT_W'(phase_limit[p]));
            for (int n = 0; n < phase_items[p]; n++)
            begin
                slot = IDX_W'($urandom);
                if ($urandom_range(0, 99) < phase_alloc[p])
                    op = OP_ALLOC;
                else
                begin
                    op = OP_FREE;
                    if (lent_slots.size() != 0 && $urandom_range(0, 99) < 85)
                    begin
                        // lean on the newest slot to exercise boundary lowering
                        if ($urandom_range(0, 99) < 40)
                            pick = lent_slots.size() - 1;
                        else
                            pick = $urandom_range(0, lent_slots.size() - 1);
                        slot = lent_slots[pick];
                        lent_slots.delete(pick);
                    end
                    else if ($urandom_range(0, 1) == 0)
                        slot = bump[IDX_W-1:0];
                end
                send_item(op, slot, 1'b0, none);
                if ($urandom_range(0, 299) == 0)
                    drain();
            end
        end

        drain();
        repeat (12) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
